### src/crast_pkg.sv
`default_nettype none
package crast_pkg;

  // input selector codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // eight-way symmetry: pixels per octant point
  localparam int unsigned MIRRORS  = 8;
  localparam int unsigned IDX_BITS = $clog2(MIRRORS);

endpackage
`default_nettype wire

### src/crast_fifo.sv
`default_nettype none
// two-entry job queue between front and emitter
module crast_fifo #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int unsigned DEPTH = 2;

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != 2'(DEPTH));
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### src/crast_front.sv
`default_nettype none
// Takes start/step words, runs the midpoint decision and queues one job per word.
// Job layout, low bit up: y, x, cy, cx, done flag.
module crast_front #(
  parameter int unsigned COORD_BITS  = 11,
  parameter int unsigned RADIUS_BITS = 10,
  localparam int unsigned JOB_W      = 1 + 2 * COORD_BITS + 2 * RADIUS_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   func,
  input  wire logic [COORD_BITS-1:0]  center_x,
  input  wire logic [COORD_BITS-1:0]  center_y,
  input  wire logic [RADIUS_BITS-1:0] radius,
  output logic                        job_valid,
  input  wire logic                   job_ready,
  output logic [JOB_W-1:0]            job_data
);

  localparam int unsigned DW = RADIUS_BITS + 6;
  localparam int unsigned R1 = RADIUS_BITS + 1;
  localparam int unsigned R2 = RADIUS_BITS + 2;

  logic [RADIUS_BITS-1:0] octant_x_r, octant_x_nxt;
  logic [RADIUS_BITS-1:0] octant_y_r, octant_y_nxt;
  logic signed [DW-1:0]   decision_r, decision_nxt;
  logic [COORD_BITS-1:0]  origin_x_r, origin_x_nxt;
  logic [COORD_BITS-1:0]  origin_y_r, origin_y_nxt;
  logic                   drawing_r, drawing_nxt;

  logic                   accept;
  logic signed [DW-1:0]   x_ext;
  logic signed [DW-1:0]   y_ext;
  logic signed [DW-1:0]   r_ext;
  logic signed [DW-1:0]   inc_keep;
  logic signed [DW-1:0]   inc_diag;
  logic                   d_neg;
  logic [R1-1:0]          x_inc;
  logic [R1-1:0]          y_dec;
  logic                   passed;

  logic                   job_done;
  logic [COORD_BITS-1:0]  job_cx;
  logic [COORD_BITS-1:0]  job_cy;
  logic [RADIUS_BITS-1:0] job_x;
  logic [RADIUS_BITS-1:0] job_y;

  assign accept    = in_valid && in_ready;
  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign job_data  = {job_done, job_cx, job_cy, job_x, job_y};

  assign x_ext    = signed'(DW'(octant_x_r));
  assign y_ext    = signed'(DW'(octant_y_r));
  assign r_ext    = signed'(DW'(radius));
  assign inc_keep = (x_ext <<< 2) + DW'(6);
  assign inc_diag = ((x_ext - y_ext) <<< 2) + DW'(10);
  assign d_neg    = decision_r[DW-1];
  assign x_inc    = R1'(octant_x_r) + R1'(1);
  assign y_dec    = R1'(octant_y_r) - R1'(1);
  // x passes y after the move; compared before the move to keep it unsigned
  assign passed   = d_neg ? (R2'(octant_x_r) + R2'(1) > R2'(octant_y_r))
                          : (R2'(octant_x_r) + R2'(2) > R2'(octant_y_r));

  always_comb begin
    octant_x_nxt = octant_x_r;
    octant_y_nxt = octant_y_r;
    decision_nxt = decision_r;
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    drawing_nxt  = drawing_r;
    job_done     = 1'b1;
    job_cx       = origin_x_r;
    job_cy       = origin_y_r;
    job_x        = octant_x_r;
    job_y        = octant_y_r;
    if (func == crast_pkg::FUNC_START) begin
      origin_x_nxt = center_x;
      origin_y_nxt = center_y;
      octant_x_nxt = '0;
      octant_y_nxt = radius;
      decision_nxt = DW'(3) - (r_ext <<< 1);
      drawing_nxt  = 1'b1;
      job_done     = 1'b0;
      job_cx       = center_x;
      job_cy       = center_y;
      job_x        = '0;
      job_y        = radius;
    end else if (drawing_r) begin
      octant_x_nxt = x_inc[RADIUS_BITS-1:0];
      if (d_neg) begin
        decision_nxt = decision_r + inc_keep;
      end else begin
        decision_nxt = decision_r + inc_diag;
        octant_y_nxt = y_dec[RADIUS_BITS-1:0];
      end
      job_x = octant_x_nxt;
      job_y = octant_y_nxt;
      if (passed) begin
        drawing_nxt = 1'b0;
      end else begin
        job_done = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octant_x_r <= '0;
      octant_y_r <= '0;
      decision_r <= '0;
      origin_x_r <= '0;
      origin_y_r <= '0;
      drawing_r  <= 1'b0;
    end else if (accept) begin
      octant_x_r <= octant_x_nxt;
      octant_y_r <= octant_y_nxt;
      decision_r <= decision_nxt;
      origin_x_r <= origin_x_nxt;
      origin_y_r <= origin_y_nxt;
      drawing_r  <= drawing_nxt;
    end
  end

endmodule
`default_nettype wire

### src/crast_emit.sv
`default_nettype none
// Plays one job out as eight mirror pixels, or a single done word.
module crast_emit #(
  parameter int unsigned COORD_BITS  = 11,
  parameter int unsigned RADIUS_BITS = 10,
  localparam int unsigned JOB_W      = 1 + 2 * COORD_BITS + 2 * RADIUS_BITS,
  localparam int unsigned PIX_W      = COORD_BITS + 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire logic [JOB_W-1:0]  job_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PIX_W-1:0]       pixel_x,
  output logic [PIX_W-1:0]       pixel_y,
  output logic                   pixel_valid,
  output logic                   circle_done,
  output logic                   last
);

  localparam int unsigned IB = crast_pkg::IDX_BITS;
  localparam int unsigned SW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
  localparam logic [IB-1:0] IDX_LAST = IB'(crast_pkg::MIRRORS - 1);

  logic                   busy_r;
  logic                   done_job_r;
  logic [COORD_BITS-1:0]  cx_r;
  logic [COORD_BITS-1:0]  cy_r;
  logic [RADIUS_BITS-1:0] x_r;
  logic [RADIUS_BITS-1:0] y_r;
  logic [IB-1:0]          idx_r;

  logic                   out_valid_r;
  logic [PIX_W-1:0]       pixel_x_r, pixel_x_nxt;
  logic [PIX_W-1:0]       pixel_y_r, pixel_y_nxt;
  logic                   pixel_valid_r;
  logic                   circle_done_r;
  logic                   last_r, last_nxt;

  logic                   advance;
  logic                   final_word;
  logic                   load;
  logic                   col_use_y;
  logic                   col_neg;
  logic                   row_neg;
  logic [SW-1:0]          col_off;
  logic [SW-1:0]          row_off;
  logic [SW-1:0]          col_sum;
  logic [SW-1:0]          row_sum;

  assign advance    = busy_r && (!out_valid_r || out_ready);
  assign final_word = done_job_r || (idx_r == IDX_LAST);
  assign load       = !busy_r || (advance && final_word);
  assign job_ready  = load;

  // mirror order: (+x,+y) (+y,+x) (+y,-x) (+x,-y) (-x,-y) (-y,-x) (-y,+x) (-x,+y)
  assign col_use_y = idx_r[0] ^ idx_r[1];
  assign col_neg   = idx_r[2];
  assign row_neg   = idx_r[1] ^ idx_r[2];
  assign col_off   = col_use_y ? SW'(y_r) : SW'(x_r);
  assign row_off   = col_use_y ? SW'(x_r) : SW'(y_r);
  assign col_sum   = col_neg ? (SW'(cx_r) - col_off) : (SW'(cx_r) + col_off);
  assign row_sum   = row_neg ? (SW'(cy_r) - row_off) : (SW'(cy_r) + row_off);

  assign pixel_x_nxt = done_job_r ? '0 : col_sum[PIX_W-1:0];
  assign pixel_y_nxt = done_job_r ? '0 : row_sum[PIX_W-1:0];
  assign last_nxt    = final_word;

  assign out_valid   = out_valid_r;
  assign pixel_x     = pixel_x_r;
  assign pixel_y     = pixel_y_r;
  assign pixel_valid = pixel_valid_r;
  assign circle_done = circle_done_r;
  assign last        = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        busy_r <= job_valid;
        idx_r  <= '0;
      end else if (advance) begin
        idx_r <= idx_r + IB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      {done_job_r, cx_r, cy_r, x_r, y_r} <= job_data;
    end
    if (advance) begin
      pixel_x_r     <= pixel_x_nxt;
      pixel_y_r     <= pixel_y_nxt;
      pixel_valid_r <= !done_job_r;
      circle_done_r <= done_job_r;
      last_r        <= last_nxt;
    end
  end

endmodule
`default_nettype wire

### src/circle_rasterizer.sv
`default_nettype none
// Each job is registered in the queue, then in the emitter, then in the output register.
// Throughput: one result word per cycle while out_tready is high; a start or step word yields
// eight mirror pixels through the single output register, a done word yields one word.
// A two-entry job queue lets new words be taken while pixels are still going out.
// Reset: synchronous, active low; octant state cleared, no circle in progress, queue empty.
module circle_rasterizer #(
  parameter int unsigned COORD_BITS  = 11,
  parameter int unsigned RADIUS_BITS = 10,
  localparam int unsigned PIX_W      = COORD_BITS + 2,
  localparam int unsigned IN_W       = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W      = ((2 * PIX_W + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,  // center_x, center_y, radius
  input  wire logic [0:0]       in_tuser,  // func
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata, // pixel_x, pixel_y
  output logic [1:0]            out_tuser, // pixel_valid, circle_done
  output logic                  out_tlast
);

  localparam int unsigned JOB_W = 1 + 2 * COORD_BITS + 2 * RADIUS_BITS;

  logic                   front_valid;
  logic                   front_ready;
  logic [JOB_W-1:0]       front_data;
  logic                   job_valid;
  logic                   job_ready;
  logic [JOB_W-1:0]       job_data;
  logic [PIX_W-1:0]       pixel_x;
  logic [PIX_W-1:0]       pixel_y;
  logic                   pixel_valid;
  logic                   circle_done;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius;

  assign center_x = in_tdata[COORD_BITS-1:0];
  assign center_y = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign radius   = in_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];

  assign out_tdata = OUT_W'({pixel_y, pixel_x});
  assign out_tuser = {circle_done, pixel_valid};

  crast_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .func      (in_tuser[0]),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job_data  (front_data)
  );

  crast_fifo #(
    .WIDTH (JOB_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_data),
    .rd_valid (job_valid),
    .rd_ready (job_ready),
    .rd_data  (job_data)
  );

  crast_emit #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job_data    (job_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_valid (pixel_valid),
    .circle_done (circle_done),
    .last        (out_tlast)
  );

endmodule
`default_nettype wire
